### src/swe_pkg.sv
// ============================================================================
// swe_pkg: shared types and constants for the spaced word extractor
// Holds the channel word types, the window read word, register indexes and
// the nucleotide encoder.
// ============================================================================
package swe_pkg;

    // Fixed field widths
    localparam int SYMBOL_W = 8;
    localparam int OUT_W    = 64;
    localparam int CODE_W   = 3;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SPAN = 1'd1;

    // Window code: bit 2 marks an invalid character, bits 1:0 are the base
    localparam logic [CODE_W-1:0] CODE_A       = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C       = 3'd1;
    localparam logic [CODE_W-1:0] CODE_T       = 3'd2;
    localparam logic [CODE_W-1:0] CODE_G       = 3'd3;
    localparam logic [CODE_W-1:0] CODE_INVALID = 3'd4;
    localparam int               CODE_BAD_BIT = 2;

    // ASCII characters that encode to a base
    localparam logic [SYMBOL_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [SYMBOL_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [SYMBOL_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [SYMBOL_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [SYMBOL_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [SYMBOL_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [SYMBOL_W-1:0] CHAR_T_LO = 8'h74;
    localparam logic [SYMBOL_W-1:0] CHAR_G_LO = 8'h67;

    // Input word: one raw character
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                end_of_read;
    } in_word_t;

    // Output word: one spaced word
    typedef struct packed {
        logic [OUT_W-1:0] word;
        logic             is_reverse;
        logic             last_of_run;
    } out_word_t;

    // Registered read data of the window, one code for each word
    typedef struct packed {
        logic [CODE_W-1:0] code_f;
        logic [CODE_W-1:0] code_r;
    } win_rd_t;

    // Map a raw character to its window code; case does not matter.
    function automatic logic [CODE_W-1:0] encode_symbol(input logic [SYMBOL_W-1:0] c);
        logic [CODE_W-1:0] code;
        case (c) inside
            CHAR_A_UP, CHAR_A_LO: code = CODE_A;
            CHAR_C_UP, CHAR_C_LO: code = CODE_C;
            CHAR_T_UP, CHAR_T_LO: code = CODE_T;
            CHAR_G_UP, CHAR_G_LO: code = CODE_G;
            default:              code = CODE_INVALID;
        endcase
        return code;
    endfunction

endpackage

### src/swe_window.sv
// ============================================================================
// swe_window: circular symbol window with two read ports
// Stores the most recent symbol codes and returns, from registered read ports, the codes
// at two window indexes counted back from the newest symbol (index 0).
// ============================================================================
module swe_window #(
    parameter int MAX_SPAN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [swe_pkg::CODE_W-1:0]          wr_code,
    input  logic [((MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1)-1:0] idx_f,
    input  logic [((MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1)-1:0] idx_r,
    output swe_pkg::win_rd_t                    rd
);

    localparam int PTR_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam logic [PTR_W:0] DEPTH    = (PTR_W + 1)'(MAX_SPAN);
    localparam logic [PTR_W-1:0] LAST_AD = PTR_W'(MAX_SPAN - 1);

    logic [swe_pkg::CODE_W-1:0] mem [MAX_SPAN];
    logic [PTR_W-1:0]           newest_reg;
    logic [PTR_W-1:0]           newest_next;
    logic [PTR_W-1:0]           addr_f;
    logic [PTR_W-1:0]           addr_r;
    swe_pkg::win_rd_t           rd_reg;

    // Address of the next write, wrapping at the depth.
    always_comb
    begin
        newest_next = (newest_reg == LAST_AD) ? '0 : newest_reg + 1'b1;
    end

    // Window index to memory address: newest minus index, modulo the depth.
    function automatic logic [PTR_W-1:0] win_addr(input logic [PTR_W-1:0] newest,
                                                  input logic [PTR_W-1:0] idx);
        logic [PTR_W:0] sum;
        if (newest >= idx)
        begin
            sum = {1'b0, newest} - {1'b0, idx};
        end
        else
        begin
            sum = {1'b0, newest} + DEPTH - {1'b0, idx};
        end
        return sum[PTR_W-1:0];
    endfunction

    always_comb
    begin
        addr_f = win_addr(newest_reg, idx_f);
        addr_r = win_addr(newest_reg, idx_r);
    end

    // Newest pointer moves on every write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
        end
        else if (wr_en)
        begin
            newest_reg <= newest_next;
        end
    end

    // Storage: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[newest_next] <= wr_code;
        end
        rd_reg.code_f <= mem[addr_f];
        rd_reg.code_r <= mem[addr_r];
    end

    assign rd = rd_reg;

endmodule

### src/spaced_word_extractor.sv
// ============================================================================
// spaced_word_extractor: spaced words with reverse complement
// Sliding nucleotide window that emits forward and reverse complement spaced
// words selected by a configurable match pattern.
// ============================================================================
// Each accepted symbol is written into the window. While the window holds
// fewer symbols than the pattern span the symbol is taken and gives no words.
// Once it is full, a sequencer walks the span one position per cycle through
// the two read ports of the window memory, building both words together,
// then drains the last read, checks both words and delivers them, longer
// while the result side stalls; the input stalls during that time.
// The forward word comes first, then the reverse complement word; a word with
// an invalid base or equal to all ones is dropped, and last_of_run marks the
// final word of a symbol. A symbol flagged end_of_read still gives its words,
// and the window starts empty after it. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module spaced_word_extractor #(
    parameter int MAX_SPAN  = 64,
    parameter int WORD_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [swe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swe_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               sym_valid,
    output logic                               sym_stall,
    input  swe_pkg::in_word_t                  sym_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output swe_pkg::out_word_t                 res_data
);

    localparam int PTR_W  = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int LIMIT  = WORD_BITS / 2;
    localparam int CNT_W  = $clog2(LIMIT + 1);
    localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(MAX_SPAN);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(LIMIT);
    localparam int OW = swe_pkg::OUT_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_SEND   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [63:0]       mask_reg;
    logic [6:0]        span_cfg_reg;
    logic [SPAN_W-1:0] seen_reg, seen_next;
    logic [SPAN_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              okf_reg, okf_next;
    logic              okr_reg, okr_next;
    logic [OW-1:0]     fw_reg, fw_next;
    logic [OW-1:0]     rv_reg, rv_next;
    logic              pvld_reg, pvld_next;
    logic              pend_f_reg, pend_f_next;
    logic              pend_r_reg, pend_r_next;
    logic              res_valid_reg, res_valid_next;
    swe_pkg::out_word_t res_reg, res_next;

    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] seen_inc;
    logic [8:0]        span9;
    logic [8:0]        pos9;
    logic              mask_bit;
    logic              sym_take;
    logic              res_take;
    logic [6:0]        bitpos;
    logic [SPAN_W-1:0] idx_f_full;
    swe_pkg::win_rd_t  rd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= 64'd1;
            span_cfg_reg <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swe_pkg::REG_PATTERN_MASK: mask_reg     <= cfg_data;
                swe_pkg::REG_PATTERN_SPAN: span_cfg_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Effective span: zero counts as one, and it never exceeds the window.
    always_comb
    begin
        span9 = {2'b00, span_cfg_reg};
        if (span9 == 9'd0)
        begin
            span9 = 9'd1;
        end
        if (span9 > 9'(MAX_SPAN))
        begin
            span9 = 9'(MAX_SPAN);
        end
        span = span9[SPAN_W-1:0];
    end

    // Pattern bit of the position being issued; positions 64 and up never match.
    always_comb
    begin
        pos9     = 9'(pos_reg);
        mask_bit = (pos9 < 9'd64) && mask_reg[pos9[5:0]];
    end

    assign sym_take   = sym_valid && !sym_stall;
    assign res_take   = !res_valid_reg || !res_stall;
    assign seen_inc   = (seen_reg == SPAN_MAX) ? seen_reg : seen_reg + 1'b1;
    assign idx_f_full = span - 1'b1 - pos_reg;
    assign bitpos     = 7'd62 - 7'({cnt_reg, 1'b0});

    // Window memory, read by forward and reverse index.
    swe_window #(
        .MAX_SPAN (MAX_SPAN)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sym_take),
        .wr_code (swe_pkg::encode_symbol(sym_data.symbol)),
        .idx_f   (idx_f_full[PTR_W-1:0]),
        .idx_r   (pos_reg[PTR_W-1:0]),
        .rd      (rd)
    );

    // Sequencer and word builder.
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        okf_next       = okf_reg;
        okr_next       = okr_reg;
        fw_next        = fw_reg;
        rv_next        = rv_reg;
        pend_f_next    = pend_f_reg;
        pend_r_next    = pend_r_reg;
        pvld_next      = (state_reg == ST_SCAN) && mask_bit;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;

        // Fold in the codes read for the previous matching position.
        if (pvld_reg && (cnt_reg < CNT_MAX))
        begin
            okf_next = okf_reg && !rd.code_f[swe_pkg::CODE_BAD_BIT];
            okr_next = okr_reg && !rd.code_r[swe_pkg::CODE_BAD_BIT];
            fw_next[bitpos[5:0] +: 2] = rd.code_f[1:0];
            rv_next[bitpos[5:0] +: 2] = rd.code_r[1:0] ^ 2'b10;
            cnt_next = cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sym_take)
                begin
                    seen_next = sym_data.end_of_read ? '0 : seen_inc;
                    pos_next  = '0;
                    cnt_next  = '0;
                    okf_next  = 1'b1;
                    okr_next  = 1'b1;
                    fw_next   = '0;
                    rv_next   = '0;
                    if (seen_inc >= span)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pos_reg == span - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                pend_f_next = okf_reg && (fw_reg != {OW{1'b1}});
                pend_r_next = okr_reg && (rv_reg != {OW{1'b1}});
                state_next  = ST_SEND;
            end
            ST_SEND:
            begin
                if (res_take)
                begin
                    if (pend_f_reg)
                    begin
                        res_valid_next       = 1'b1;
                        res_next.word        = fw_reg;
                        res_next.is_reverse  = 1'b0;
                        res_next.last_of_run = !pend_r_reg;
                        pend_f_next          = 1'b0;
                        if (!pend_r_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else if (pend_r_reg)
                    begin
                        res_valid_next       = 1'b1;
                        res_next.word        = rv_reg;
                        res_next.is_reverse  = 1'b1;
                        res_next.last_of_run = 1'b1;
                        pend_r_next          = 1'b0;
                        state_next           = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            pvld_reg      <= 1'b0;
            pend_f_reg    <= 1'b0;
            pend_r_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            pvld_reg      <= pvld_next;
            pend_f_reg    <= pend_f_next;
            pend_r_reg    <= pend_r_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Word payload registers.
    always_ff @(posedge clk)
    begin
        okf_reg <= okf_next;
        okr_reg <= okr_next;
        fw_reg  <= fw_next;
        rv_reg  <= rv_next;
        res_reg <= res_next;
    end

    assign sym_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // A forward word that is not the last is followed at once by its reverse word.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res_data.last_of_run |=> res_valid && res_data.is_reverse)
    else $error("reverse word did not follow a non-final forward word");

    // A reverse word always closes the run of its symbol.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.is_reverse |-> res_data.last_of_run)
    else $error("reverse word without last_of_run");

    // The packed position count never passes the word capacity, nor the fill count the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX && seen_reg <= SPAN_MAX)
    else $error("position count or fill count out of range");

    // Words are only loaded while the sequencer is delivering them.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg && res_valid_next |-> state_reg == ST_SEND)
    else $error("output loaded outside the delivery state");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for the spaced word extractor
// Streams reads of nucleotide characters through the block under a range of
// match patterns and spans, predicts the forward and reverse complement words
// of every accepted symbol, and checks each delivered word in order.
// ============================================================================
module tb_top;

    localparam int CLK_PERIOD    = 8;
    localparam int WIN_DEPTH     = 64;
    localparam int WORD_LEN      = 64;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 500;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int PHASES        = 12;

    // Reference behavior of the block: window of codes, newest at index 0.
    class spaced_word_board;
        logic [swe_pkg::CODE_W-1:0] window [WIN_DEPTH];
        int unsigned                filled;
        logic [swe_pkg::CFG_W-1:0]  match_mask;
        logic [6:0]                 span_reg;
        swe_pkg::out_word_t         expected_words [$];
        int                         errors;

        function new();
            foreach (window[i]) window[i] = swe_pkg::CODE_INVALID;
            filled     = 0;
            match_mask = 64'd1;
            span_reg   = 7'd1;
            errors     = 0;
        endfunction

        function void write_reg(logic [swe_pkg::CFG_IDX_W-1:0] idx,
                                logic [swe_pkg::CFG_W-1:0] data);
            if (idx == swe_pkg::REG_PATTERN_MASK)
                match_mask = data;
            else if (idx == swe_pkg::REG_PATTERN_SPAN)
                span_reg = data[6:0];
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Append one word to the tail of the expected list.
        function void add_expected(swe_pkg::out_word_t o);
            expected_words.insert(expected_words.size(), o);
        endfunction

        // Map a raw character to a 2-bit base, or to the invalid code.
        function logic [swe_pkg::CODE_W-1:0] char_code(logic [swe_pkg::SYMBOL_W-1:0] c);
            logic [swe_pkg::SYMBOL_W-1:0] up;
            up = c;
            // Fold lower case letters onto upper case.
            if (c >= 8'h61 && c <= 8'h7A)
                up = c - 8'h20;
            if (up == swe_pkg::CHAR_A_UP) return swe_pkg::CODE_A;
            if (up == swe_pkg::CHAR_C_UP) return swe_pkg::CODE_C;
            if (up == swe_pkg::CHAR_T_UP) return swe_pkg::CODE_T;
            if (up == swe_pkg::CHAR_G_UP) return swe_pkg::CODE_G;
            return swe_pkg::CODE_INVALID;
        endfunction

        // Shift the symbol in and queue the spaced words that it produces.
        function void note_symbol(swe_pkg::in_word_t w);
            int unsigned                eff;
            int unsigned                count;
            logic [swe_pkg::CODE_W-1:0] f, r;
            logic [1:0]                 rc;
            logic [63:0]                fw, rv;
            bit                         okf, okr, emit_f, emit_r;
            swe_pkg::out_word_t         o;
            eff = (span_reg == 0) ? 1 : ((span_reg > WIN_DEPTH) ? WIN_DEPTH : span_reg);
            for (int i = WIN_DEPTH - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = char_code(w.symbol);
            if (filled < WIN_DEPTH)
                filled++;
            if (filled >= eff)
            begin
                fw = '0;
                rv = '0;
                okf = 1'b1;
                okr = 1'b1;
                count = 0;
                // Walk the match positions, oldest window position first.
                for (int i = 0; i < eff && count < WORD_LEN / 2; i++)
                begin
                    if (match_mask[i])
                    begin
                        f = window[eff-1-i];
                        r = window[i];
                        if (f == swe_pkg::CODE_INVALID) okf = 1'b0;
                        if (r == swe_pkg::CODE_INVALID) okr = 1'b0;
                        rc = r[1:0] + 2'd2;
                        fw = {fw[61:0], f[1:0]};
                        rv = {rv[61:0], rc};
                        count++;
                    end
                end
                // Left align partial words.
                if (count > 0 && count < WORD_LEN / 2)
                begin
                    fw = fw << (WORD_LEN - 2 * count);
                    rv = rv << (WORD_LEN - 2 * count);
                end
                emit_f = okf && (fw != '1);
                emit_r = okr && (rv != '1);
                if (emit_f)
                begin
                    o.word = fw;
                    o.is_reverse = 1'b0;
                    o.last_of_run = !emit_r;
                    add_expected(o);
                end
                if (emit_r)
                begin
                    o.word = rv;
                    o.is_reverse = 1'b1;
                    o.last_of_run = 1'b1;
                    add_expected(o);
                end
            end
            // The read ends here: the window starts over empty.
            if (w.end_of_read)
            begin
                foreach (window[i]) window[i] = swe_pkg::CODE_INVALID;
                filled = 0;
            end
        endfunction

        function void field_mismatch(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v != got_v)
            begin
                $error("%s mismatch: expected %h, actual %h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Compare a delivered word with the oldest expected one.
        function void check_word(swe_pkg::out_word_t got);
            swe_pkg::out_word_t exp_w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word %h (is_reverse %0b, last_of_run %0b)",
                       got.word, got.is_reverse, got.last_of_run);
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            field_mismatch("word", exp_w.word, got.word);
            field_mismatch("is_reverse", 64'(exp_w.is_reverse), 64'(got.is_reverse));
            field_mismatch("last_of_run", 64'(exp_w.last_of_run), 64'(got.last_of_run));
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [swe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [swe_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                          sym_valid = 1'b0;
    logic                          sym_stall;
    swe_pkg::in_word_t             sym_data  = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    swe_pkg::out_word_t            res_data;

    spaced_word_board board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int read_left      = 0;
    bit read_repeats   = 1'b0;
    logic [swe_pkg::CODE_W-1:0] read_base = swe_pkg::CODE_A;
    int send_pcts [4]  = '{0, 49, 0, 19};
    int recv_pcts [4]  = '{0, 0, 49, 19};

    spaced_word_extractor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_data  (sym_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result side stall: random, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watch both handshakes and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sym_valid && !sym_stall)
                board.note_symbol(sym_data);
            if (res_valid && !res_stall)
                board.check_word(res_data);
        end
    end

    // Run limit.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offer one character and hold it until the block takes it.
    task automatic send_symbol(input logic [swe_pkg::SYMBOL_W-1:0] ch, input logic eor);
        swe_pkg::in_word_t w;
        w.symbol      = ch;
        w.end_of_read = eor;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            sym_valid <= 1'b0;
            @(posedge clk);
        end
        sym_valid <= 1'b1;
        sym_data  <= w;
        do @(posedge clk); while (sym_stall);
    endtask

    // Drop valid, wait for every expected word, then let the block settle.
    task automatic wait_idle();
        int waited;
        waited = 0;
        sym_valid <= 1'b0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both pattern registers on back to back cycles.
    task automatic load_pattern(input logic [swe_pkg::CFG_W-1:0] mask, input logic [6:0] span);
        logic [swe_pkg::CFG_W-1:0] span_data;
        span_data = {$urandom, $urandom};
        span_data[6:0] = span;
        cfg_we    <= 1'b1;
        cfg_index <= swe_pkg::REG_PATTERN_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        board.write_reg(swe_pkg::REG_PATTERN_MASK, mask);
        cfg_index <= swe_pkg::REG_PATTERN_SPAN;
        cfg_data  <= span_data;
        @(posedge clk);
        board.write_reg(swe_pkg::REG_PATTERN_SPAN, span_data);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [swe_pkg::SYMBOL_W-1:0] base_char(logic [swe_pkg::CODE_W-1:0] b,
                                                               bit lower);
        case (b)
            swe_pkg::CODE_A: return lower ? swe_pkg::CHAR_A_LO : swe_pkg::CHAR_A_UP;
            swe_pkg::CODE_C: return lower ? swe_pkg::CHAR_C_LO : swe_pkg::CHAR_C_UP;
            swe_pkg::CODE_T: return lower ? swe_pkg::CHAR_T_LO : swe_pkg::CHAR_T_UP;
            default:         return lower ? swe_pkg::CHAR_G_LO : swe_pkg::CHAR_G_UP;
        endcase
    endfunction

    // One random phase: new pattern, then reads that mostly fill the window.
    task automatic run_phase(input logic [swe_pkg::CFG_W-1:0] mask, input logic [6:0] span,
                             input int idle_mode, input bit hold);
        int eff;
        int roll;
        logic [swe_pkg::CODE_W-1:0] b;
        logic [swe_pkg::SYMBOL_W-1:0] ch;
        eff = (span == 0) ? 1 : ((span > WIN_DEPTH) ? WIN_DEPTH : span);
        send_idle_pct  = hold ? 0 : send_pcts[idle_mode];
        recv_stall_pct = hold ? 0 : recv_pcts[idle_mode];
        load_pattern(mask, span);
        if (hold)
            hold_requests++;
        for (int n = 0; n < 30 + 2 * eff; n++)
        begin
            // A read may run on from the previous pattern into this one.
            if (read_left == 0)
            begin
                if ($urandom_range(99) < 80)
                    read_left = $urandom_range(eff, 2 * eff + 4);
                else
                    read_left = $urandom_range(1, eff);
                read_repeats = ($urandom_range(99) < 25);
                read_base    = swe_pkg::CODE_W'($urandom_range(3));
            end
            roll = $urandom_range(99);
            if (roll < 4)
                ch = swe_pkg::SYMBOL_W'($urandom_range(255));
            else
            begin
                b = (read_repeats && roll < 90) ? read_base
                                                : swe_pkg::CODE_W'($urandom_range(3));
                ch = base_char(b, 1'($urandom_range(1)));
            end
            send_symbol(ch, read_left == 1);
            read_left--;
        end
        wait_idle();
    endtask

    initial
    begin
        logic [swe_pkg::CFG_W-1:0] mask;
        logic [6:0] span;
        int e;
        bit hold;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pattern: one position, span one; invalid and extreme characters.
        send_symbol(swe_pkg::CHAR_A_UP, 1'b0);
        send_symbol(swe_pkg::CHAR_C_LO, 1'b0);
        send_symbol(swe_pkg::CHAR_T_LO, 1'b0);
        send_symbol(swe_pkg::CHAR_G_UP, 1'b0);
        send_symbol(8'h4E, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h78, 1'b1);
        wait_idle();

        // Span zero behaves as span one.
        load_pattern('1, 7'd0);
        send_symbol(swe_pkg::CHAR_G_LO, 1'b0);
        send_symbol(swe_pkg::CHAR_C_UP, 1'b1);
        wait_idle();

        // Mask bits only beyond the span: both words come out as zero.
        load_pattern(64'hFFFF_FFFF_FFFF_FFF0, 7'd3);
        send_symbol(swe_pkg::CHAR_A_UP, 1'b0);
        send_symbol(swe_pkg::CHAR_C_UP, 1'b0);
        send_symbol(swe_pkg::CHAR_G_UP, 1'b1);
        wait_idle();

        // Gapped pattern with an invalid base passing through the window.
        load_pattern(64'h5, 7'd3);
        send_symbol(swe_pkg::CHAR_A_LO, 1'b0);
        send_symbol(swe_pkg::CHAR_T_UP, 1'b0);
        send_symbol(swe_pkg::CHAR_G_LO, 1'b0);
        send_symbol(swe_pkg::CHAR_C_LO, 1'b0);
        send_symbol(8'h6E, 1'b0);
        send_symbol(swe_pkg::CHAR_A_UP, 1'b0);
        send_symbol(swe_pkg::CHAR_C_UP, 1'b0);
        send_symbol(swe_pkg::CHAR_T_UP, 1'b1);
        wait_idle();

        // Random phases over a spread of patterns and idling styles.
        for (int p = 0; p < PHASES; p++)
        begin
            mask = {$urandom, $urandom};
            hold = 1'b0;
            case (p)
                0:
                begin
                    mask = '1;
                    span = 7'd64;
                end
                1:
                begin
                    mask = '1;
                    span = 7'd32;
                end
                2:
                begin
                    mask = 64'h8000_0000_0000_0001;
                    span = 7'd64;
                end
                3: span = 7'($urandom_range(65, 127));
                4: span = 7'($urandom_range(1, 64));
                5:
                begin
                    span = 7'd2;
                    hold = 1'b1;
                end
                6:
                begin
                    e = $urandom_range(1, 63);
                    mask = '1 << e;
                    span = 7'(e);
                end
                7: span = 7'd0;
                8: span = 7'($urandom_range(1, 16));
                9:
                begin
                    mask = '1;
                    span = 7'd16;
                end
                10: span = 7'd40;
                default:
                begin
                    mask = 64'd1;
                    span = 7'd1;
                end
            endcase
            run_phase(mask, span, p % 4, hold);
        end

        if (board.pending() != 0)
        begin
            $error("%0d expected words never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
